FILE: rtl/core/ntd_pkg.sv
// Package for the number-to-text formatter: mode codes, command and status
// structs between controller and datapath, character constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ntd_pkg;

  // Default display width in text columns
  localparam int unsigned TextColumnsDef = 16;

  // Mode codes carried in the kind field
  typedef enum logic [1:0] {
    KIND_UDEC = 2'd0,
    KIND_SDEC = 2'd1,
    KIND_HEX  = 2'd2,
    KIND_BIN  = 2'd3
  } kind_e;

  // Limits
  localparam logic [4:0] MaxCountDec = 5'd10;
  localparam logic [4:0] MaxCountHex = 5'd8;
  localparam logic [4:0] MaxCountBin = 5'd16;
  localparam logic [3:0] MaxLine     = 4'd4;
  localparam int unsigned DecDigits  = 10;
  localparam int unsigned ConvSteps  = 32;

  // ASCII codes
  localparam logic [6:0] CharZero  = 7'h30;
  localparam logic [6:0] CharUpA   = 7'h41;
  localparam logic [6:0] CharPlus  = 7'h2B;
  localparam logic [6:0] CharMinus = 7'h2D;
  localparam logic [6:0] CharNone  = 7'h00;

  // Controller to datapath
  typedef struct packed {
    logic take;        // input side may accept a word
    logic conv_step;   // one shift-and-add-3 step
    logic emit_sign;
    logic emit_digit;
    logic emit_err;
  } ntd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_valid;
    logic bad;
    logic is_dec;
    logic is_signed;
    logic last_digit;
    logic out_free;
  } ntd_status_t;

  // One digit value (0..15) to its ASCII code
  function automatic logic [6:0] digit_to_ascii(input logic [3:0] d);
    logic [6:0] code;
    if (d < 4'd10) begin
      code = CharZero + {3'b000, d};
    end else begin
      code = CharUpA + {3'b000, d} - 7'd10;
    end
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ntd_in_if.sv
// Input channel of the formatter: valid/ready plus the request word.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ntd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] number;
  logic [4:0]  digit_count;
  logic [3:0]  text_line;
  logic [4:0]  start_column;

  modport source (output valid, kind, number, digit_count, text_line, start_column,
                  input ready);
  modport sink   (input valid, kind, number, digit_count, text_line, start_column,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ntd_out_if.sv
// Output channel of the formatter: valid/ready plus one character word.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ntd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] out_line;
  logic [4:0] out_column;
  logic [6:0] char_code;
  logic       last;
  logic       status;

  modport source (output valid, out_line, out_column, char_code, last, status,
                  input ready);
  modport sink   (input valid, out_line, out_column, char_code, last, status,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ntd_ctrl.sv
// Controller of the formatter: sequences check, binary-to-BCD steps and
// character emission. Depends on ntd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ntd_ctrl import ntd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ntd_status_t status_i,
  output ntd_cmd_t         cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PREP  = 6'b000010,
    S_CONV  = 6'b000100,
    S_SIGN  = 6'b001000,
    S_DIGIT = 6'b010000,
    S_ERR   = 6'b100000
  } state_e;

  localparam int unsigned StepW = $clog2(ConvSteps);
  localparam logic [StepW-1:0] StepLast = StepW'(ConvSteps - 1);
  localparam logic [StepW-1:0] StepOne  = StepW'(1);

  state_e state_q, state_d;
  logic [StepW-1:0] step_q, step_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.take = 1'b1;
        if (status_i.in_valid) state_d = S_PREP;
      end
      S_PREP: begin
        step_d = '0;
        if (status_i.bad) begin
          state_d = S_ERR;
        end else if (status_i.is_dec) begin
          state_d = S_CONV;
        end else begin
          state_d = S_DIGIT;
        end
      end
      S_CONV: begin
        cmd_o.conv_step = 1'b1;
        step_d = step_q + StepOne;
        if (step_q == StepLast) begin
          state_d = status_i.is_signed ? S_SIGN : S_DIGIT;
        end
      end
      S_SIGN: begin
        if (status_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          if (status_i.last_digit) state_d = S_IDLE;
        end
      end
      S_ERR: begin
        if (status_i.out_free) begin
          cmd_o.emit_err = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

`ifndef SYNTHESIS
  // A sign character only follows a finished conversion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SIGN) |-> ($past(state_q) == S_CONV || $past(state_q) == S_SIGN))
    else $error("sign state entered without conversion");

  // Conversion always starts from a cleared step count, so it runs the full step count before leaving
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CONV && $past(state_q) != S_CONV) |-> (step_q == '0))
    else $error("conversion started with stale step count");

  // Error path never goes through conversion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CONV) |-> !status_i.bad)
    else $error("conversion on a rejected request");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/ntd_datapath.sv
// Datapath of the formatter: request registers, parameter check, BCD
// conversion, digit selection and output register. Depends on ntd_pkg and
// the channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

module ntd_datapath import ntd_pkg::*; #(
  parameter int unsigned TEXT_COLUMNS = TextColumnsDef
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  ntd_in_if.sink       in_i,
  ntd_out_if.source    out_o,
  input  wire ntd_cmd_t cmd_i,
  output ntd_status_t  status_o
);

  kind_e       kind_q;
  logic [31:0] mag_q;
  logic [3:0]  bcd_q [DecDigits];
  logic [4:0]  idx_q;
  logic [4:0]  col_q;
  logic [3:0]  line_q;
  logic        neg_q;
  logic        bad_q;

  logic        out_valid_q;
  logic [3:0]  out_line_q;
  logic [4:0]  out_col_q;
  logic [6:0]  out_char_q;
  logic        out_last_q;
  logic        out_status_q;

  logic        load;
  logic        out_free;
  kind_e       in_kind;
  logic [4:0]  max_count;
  logic [6:0]  col_end;
  logic        bad_in;
  logic [31:0] mag_in;
  logic [3:0]  adj [DecDigits];
  logic [3:0]  digit;

  assign load     = in_i.valid & cmd_i.take;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = cmd_i.take;
  assign in_kind  = kind_e'(in_i.kind);

  // Parameter check on the incoming word
  always_comb begin
    unique case (in_kind)
      KIND_UDEC, KIND_SDEC: max_count = MaxCountDec;
      KIND_HEX:             max_count = MaxCountHex;
      default:              max_count = MaxCountBin;
    endcase
    col_end = {2'b00, in_i.start_column} + {2'b00, in_i.digit_count}
            + {6'd0, in_kind == KIND_SDEC};
    bad_in = (in_i.digit_count == 5'd0) || (in_i.digit_count > max_count)
          || (col_end > 7'(TEXT_COLUMNS))
          || (in_i.text_line == 4'd0) || (in_i.text_line > MaxLine)
          || (in_i.start_column == 5'd0);
  end

  // Two's complement magnitude in signed mode; -2^31 maps to 2^31 naturally
  assign mag_in = (in_kind == KIND_SDEC && in_i.number[31]) ? (~in_i.number + 32'd1)
                                                            : in_i.number;

  // Add-3 correction on every BCD digit
  always_comb begin
    for (int j = 0; j < DecDigits; j++) begin
      adj[j] = (bcd_q[j] >= 4'd5) ? bcd_q[j] + 4'd3 : bcd_q[j];
    end
  end

  // Digit at the current index, by mode
  always_comb begin
    unique case (kind_q)
      KIND_UDEC, KIND_SDEC: digit = bcd_q[idx_q[3:0]];
      KIND_HEX:             digit = mag_q[{idx_q[2:0], 2'b00} +: 4];
      default:              digit = {3'b000, mag_q[idx_q[3:0]]};
    endcase
  end

  // Request registers and conversion
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= in_kind;
      mag_q  <= mag_in;
      idx_q  <= in_i.digit_count - 5'd1;
      col_q  <= in_i.start_column;
      line_q <= in_i.text_line;
      neg_q  <= in_i.number[31];
      bad_q  <= bad_in;
      for (int j = 0; j < DecDigits; j++) bcd_q[j] <= 4'd0;
    end else if (cmd_i.conv_step) begin
      mag_q    <= {mag_q[30:0], 1'b0};
      bcd_q[0] <= {adj[0][2:0], mag_q[31]};
      for (int j = 1; j < DecDigits; j++) bcd_q[j] <= {adj[j][2:0], adj[j-1][3]};
    end else if (cmd_i.emit_sign) begin
      col_q <= col_q + 5'd1;
    end else if (cmd_i.emit_digit) begin
      col_q <= col_q + 5'd1;
      idx_q <= idx_q - 5'd1;
    end
  end

  // Output register: control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_sign || cmd_i.emit_digit || cmd_i.emit_err) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register: payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_sign) begin
      out_line_q   <= line_q;
      out_col_q    <= col_q;
      out_char_q   <= neg_q ? CharMinus : CharPlus;
      out_last_q   <= 1'b0;
      out_status_q <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      out_line_q   <= line_q;
      out_col_q    <= col_q;
      out_char_q   <= digit_to_ascii(digit);
      out_last_q   <= (idx_q == 5'd0);
      out_status_q <= 1'b0;
    end else if (cmd_i.emit_err) begin
      out_line_q   <= line_q;
      out_col_q    <= col_q;
      out_char_q   <= CharNone;
      out_last_q   <= 1'b1;
      out_status_q <= 1'b1;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_line   = out_line_q;
  assign out_o.out_column = out_col_q;
  assign out_o.char_code  = out_char_q;
  assign out_o.last       = out_last_q;
  assign out_o.status     = out_status_q;

  assign status_o.in_valid   = in_i.valid;
  assign status_o.bad        = bad_q;
  assign status_o.is_dec     = (kind_q == KIND_UDEC) || (kind_q == KIND_SDEC);
  assign status_o.is_signed  = (kind_q == KIND_SDEC);
  assign status_o.last_digit = (idx_q == 5'd0);
  assign status_o.out_free   = out_free;

`ifndef SYNTHESIS
  // At most one character source per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.emit_sign, cmd_i.emit_digit, cmd_i.emit_err}))
    else $error("more than one emit command");

  // Never overwrite a word the sink has not taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_sign || cmd_i.emit_digit || cmd_i.emit_err) |-> out_free)
    else $error("output register overwritten");

  // Decimal digit index stays inside the BCD register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_digit && (kind_q == KIND_UDEC || kind_q == KIND_SDEC)) |-> (idx_q < 5'd10))
    else $error("decimal digit index out of range");

  // An error word is a lone last word with a null character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q) |-> (out_last_q && out_char_q == CharNone))
    else $error("malformed error word");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/number_to_text_digits.sv
// Number-to-text formatter, top level: request in, one ASCII character per
// output word. Depends on ntd_pkg, ntd_in_if, ntd_out_if, ntd_ctrl, ntd_datapath.
//
// Each accepted request (mode, 32-bit number, digit count, line, first column)
// yields its characters most significant first, one word per cycle while the
// sink is ready, each tagged with line and column; the last one carries last.
// A rejected request yields a single word with status 1 and character 0.
// The block takes one request at a time. The request is accepted and then
// checked; decimal modes then run a 32-step shift-and-add-3 binary-to-BCD
// conversion, one bit per cycle, before the characters are emitted, while
// hex and binary modes emit them right after the check. A request yields at
// most 15 characters. The next request is accepted as soon as the last
// character has entered the output register.
`timescale 1ns / 1ps
`default_nettype none

module number_to_text_digits import ntd_pkg::*; #(
  parameter int unsigned TEXT_COLUMNS = TextColumnsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ntd_in_if.sink    in_i,
  ntd_out_if.source out_o
);

  ntd_cmd_t    cmd;
  ntd_status_t status;

  ntd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  ntd_datapath #(
    .TEXT_COLUMNS (TEXT_COLUMNS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .out_o    (out_o),
    .cmd_i    (cmd),
    .status_o (status)
  );

endmodule

`default_nettype wire
